// ===== src/assert_macros.svh =====
// assertion helpers shared by the frame sync receiver modules
// both sample on clk_i and are off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication check
`define BFS_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/bfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES_DEF = 18;
  localparam int unsigned IDX_MAX_W       = 6;
  localparam int unsigned NUM_BANKS       = 2;

  // fixed positions and limits inside a frame
  localparam logic [7:0]  START_ID_MAX = 8'h10;
  localparam int unsigned CHECK_POS    = 17;
  localparam int unsigned LENGTH_POS   = 7;

  // register indexes on the config port
  localparam logic [1:0] REG_START_ID_MIN     = 2'd0;
  localparam logic [1:0] REG_CHECKED_ID_MIN   = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH_VALUE = 2'd2;

  // reset values of the registers
  localparam logic [4:0] START_ID_MIN_RST     = 5'd1;
  localparam logic [4:0] CHECKED_ID_MIN_RST   = 5'd14;
  localparam logic [7:0] MAX_LENGTH_VALUE_RST = 8'd8;

  typedef struct packed {
    logic [4:0] start_id_min;
    logic [4:0] checked_id_min;
    logic [7:0] max_length_value;
  } bfs_cfg_t;

  // frame buffer write port from front to back
  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [IDX_MAX_W-1:0] idx;
    logic [7:0]           data;
  } bfs_wr_t;

endpackage

`default_nettype wire

// ===== src/bfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface bfs_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

// frame byte channel
interface bfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       last_in_frame;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_in_frame, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input last_in_frame, output ready);
endinterface

`default_nettype wire

// ===== src/bfs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// two-entry queue of finished frame bank ids, front to back
module bfs_queue (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  wire  push_bank_i,
  input  wire  pop_i,
  output logic valid_o,
  output logic bank_o
);

  logic [1:0] slot_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_bank_i;
    end
  end

  assign valid_o = count_q != 2'd0;
  assign bank_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== src/bfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// hunts for start bytes, collects frames into the current bank and checks them
module bfs_front #(
  parameter int unsigned FRAME_BYTES = bfs_pkg::FRAME_BYTES_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  bfs_pkg::bfs_cfg_t cfg_i,
  bfs_in_if.sink           rx_i,
  input  wire              done_i,
  output bfs_pkg::bfs_wr_t wr_o,
  output logic             push_o,
  output logic             push_bank_o
);

  import bfs_pkg::*;

  localparam int unsigned IdxW     = $clog2(FRAME_BYTES);
  localparam logic [1:0]  PendFull = 2'(NUM_BANKS);

  logic            in_sync_q, in_sync_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [7:0]      xor_q, xor_d;
  logic            bank_q, bank_d;
  logic [1:0]      pending_q, pending_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      chk_q, chk_d;

  logic       accept;
  logic       push;
  logic       byte_start;
  logic       first_start;
  logic       first_checked;
  logic [7:0] chk_val;
  logic       frame_ok;

  // stall only when both banks hold frames waiting for readout
  assign rx_i.ready = pending_q != PendFull;
  assign accept     = rx_i.valid && rx_i.ready;

  // start id range and check tests
  assign byte_start    = ({3'b000, cfg_i.start_id_min} <= rx_i.rx_byte) &&
                         (rx_i.rx_byte <= START_ID_MAX);
  assign first_start   = ({3'b000, cfg_i.start_id_min} <= first_q) &&
                         (first_q <= START_ID_MAX);
  assign first_checked = {3'b000, cfg_i.checked_id_min} <= first_q;
  assign chk_val       = (fill_q == IdxW'(CHECK_POS)) ? rx_i.rx_byte : chk_q;
  assign frame_ok      = first_start &&
                         !(first_checked &&
                           ((xor_q != chk_val) || (len_q > cfg_i.max_length_value)));

  // per-item sync and fill logic
  always_comb begin
    in_sync_d = in_sync_q;
    fill_d    = fill_q;
    xor_d     = xor_q;
    bank_d    = bank_q;
    first_d   = first_q;
    len_d     = len_q;
    chk_d     = chk_q;
    push      = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.bank = bank_q;
    wr_o.idx  = IDX_MAX_W'(fill_q);
    wr_o.data = rx_i.rx_byte;
    if (accept) begin
      if (rx_i.req_type) begin
        in_sync_d = 1'b0;
        fill_d    = '0;
        xor_d     = '0;
      end else if (!in_sync_q) begin
        if (byte_start) begin
          in_sync_d = 1'b1;
          fill_d    = IdxW'(1);
          xor_d     = rx_i.rx_byte;
          first_d   = rx_i.rx_byte;
          wr_o.en   = 1'b1;
          wr_o.idx  = '0;
        end
      end else begin
        wr_o.en = 1'b1;
        fill_d  = fill_q + IdxW'(1);
        if (fill_q < IdxW'(CHECK_POS)) begin
          xor_d = xor_q ^ rx_i.rx_byte;
        end
        if (fill_q == '0) begin
          first_d = rx_i.rx_byte;
        end
        if (fill_q == IdxW'(LENGTH_POS)) begin
          len_d = rx_i.rx_byte;
        end
        if (fill_q == IdxW'(CHECK_POS)) begin
          chk_d = rx_i.rx_byte;
        end
        // frame complete: hand off or drop sync
        if (fill_q == IdxW'(FRAME_BYTES - 1)) begin
          fill_d = '0;
          xor_d  = '0;
          if (frame_ok) begin
            push   = 1'b1;
            bank_d = ~bank_q;
          end else begin
            in_sync_d = 1'b0;
          end
        end
      end
    end
  end

  // frames handed off but not yet fully read by the back
  always_comb begin
    pending_d = pending_q;
    if (push && !done_i) begin
      pending_d = pending_q + 2'd1;
    end else if (!push && done_i) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      fill_q    <= '0;
      xor_q     <= '0;
      bank_q    <= 1'b0;
      pending_q <= 2'd0;
    end else begin
      in_sync_q <= in_sync_d;
      fill_q    <= fill_d;
      xor_q     <= xor_d;
      bank_q    <= bank_d;
      pending_q <= pending_d;
    end
  end

  // captured header and check bytes
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    len_q   <= len_d;
    chk_q   <= chk_d;
  end

  assign push_o      = push;
  assign push_bank_o = bank_q;

  `BFS_ASSERT_IMP(a_no_push_when_full, push, pending_q != PendFull, "push with both banks busy")
  `BFS_ASSERT_IMP(a_hunt_is_empty, !in_sync_q, fill_q == '0 && xor_q == '0, "partial while hunting")
  `BFS_ASSERT(a_push_flips_bank, push |=> bank_q != $past(bank_q), "bank did not flip on handoff")

endmodule

`default_nettype wire

// ===== src/bfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// holds the two frame banks and streams finished frames out byte by byte
module bfs_back #(
  parameter int unsigned FRAME_BYTES = bfs_pkg::FRAME_BYTES_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  bfs_pkg::bfs_wr_t wr_i,
  input  wire              q_valid_i,
  input  wire              q_bank_i,
  output logic             pop_o,
  output logic             done_o,
  bfs_out_if.source        frame_o
);

  import bfs_pkg::*;

  localparam int unsigned IdxW  = $clog2(FRAME_BYTES);
  localparam int unsigned Depth = NUM_BANKS * (2 ** IdxW);

  logic [7:0]      mem_q [Depth];

  logic            run_q, run_d;
  logic            rd_bank_q, rd_bank_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic            st_v_q, st_v_d;
  logic [7:0]      st_byte_q;
  logic [IdxW-1:0] st_idx_q;
  logic            st_last_q;

  logic            out_v_q, out_v_d;
  logic [7:0]      out_byte_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_last_q;

  logic out_free;
  logic issue;
  logic issue_last;
  logic pop;

  assign out_free   = !out_v_q || frame_o.ready;
  assign issue      = run_q && (!st_v_q || out_free);
  assign issue_last = rd_idx_q == IdxW'(FRAME_BYTES - 1);
  assign pop        = !run_q && q_valid_i;

  // readout sequencer
  always_comb begin
    run_d     = run_q;
    rd_bank_d = rd_bank_q;
    rd_idx_d  = rd_idx_q;
    if (pop) begin
      run_d     = 1'b1;
      rd_bank_d = q_bank_i;
      rd_idx_d  = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
      if (issue_last) begin
        run_d = 1'b0;
      end
    end
  end

  // read stage and output register valids
  always_comb begin
    st_v_d = st_v_q;
    if (issue) begin
      st_v_d = 1'b1;
    end else if (out_free) begin
      st_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (out_free) begin
      out_v_d = st_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      rd_bank_q <= 1'b0;
      rd_idx_q  <= '0;
      st_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      run_q     <= run_d;
      rd_bank_q <= rd_bank_d;
      rd_idx_q  <= rd_idx_d;
      st_v_q    <= st_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // frame bank write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.idx[IdxW-1:0]}] <= wr_i.data;
    end
  end

  // registered read into the stage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      st_byte_q <= mem_q[{rd_bank_q, rd_idx_q}];
      st_idx_q  <= rd_idx_q;
      st_last_q <= issue_last;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_free && st_v_q) begin
      out_byte_q <= st_byte_q;
      out_idx_q  <= st_idx_q;
      out_last_q <= st_last_q;
    end
  end

  assign pop_o                 = pop;
  assign done_o                = issue && issue_last;
  assign frame_o.valid         = out_v_q;
  assign frame_o.frame_byte    = out_byte_q;
  assign frame_o.byte_index    = IDX_MAX_W'(out_idx_q);
  assign frame_o.last_in_frame = out_last_q;

  `BFS_ASSERT_IMP(a_last_index, out_v_q && out_last_q, out_idx_q == IdxW'(FRAME_BYTES - 1), "last flag off the final index")
  `BFS_ASSERT_IMP(a_done_in_run, done_o, run_q, "done pulse outside a readout")
  `BFS_ASSERT(a_stage_holds, st_v_q && !out_free |=> st_v_q && $stable(st_byte_q), "read stage lost data under stall")

endmodule

`default_nettype wire

// ===== src/board_link_frame_sync_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame sync receiver for a board link. Each input item is one received byte
// (or a resync request), and items are taken one per cycle while ready is
// high; frames of FRAME_BYTES bytes are collected into one of two frame banks.
// A frame that passes its start, checksum and length checks is streamed out
// one byte per cycle while the output is ready, passing the queue, readout
// sequencer, read stage and output register when the readout side is idle,
// while the next frame already fills the other bank. Input stalls only when
// both banks hold frames not yet read out. The readout sequencer sets the
// output rate at one byte per cycle and pops the next frame's bank id between
// frames, issuing no byte in that step, so input stays near one item per
// cycle as long as the output keeps up. Registers are written over the APB
// port at byte addresses 0, 4 and 8; no clearing pass follows reset.
module board_link_frame_sync_receiver #(
  parameter int unsigned FRAME_BYTES = bfs_pkg::FRAME_BYTES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bfs_in_if.sink      rx_i,
  bfs_out_if.source   frame_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bfs_pkg::*;

  bfs_cfg_t cfg_q, cfg_d;
  bfs_wr_t  wr;
  logic     push;
  logic     push_bank;
  logic     pop;
  logic     done;
  logic     q_valid;
  logic     q_bank;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (paddr[3:2])
        REG_START_ID_MIN:     cfg_d.start_id_min     = pwdata[4:0];
        REG_CHECKED_ID_MIN:   cfg_d.checked_id_min   = pwdata[4:0];
        REG_MAX_LENGTH_VALUE: cfg_d.max_length_value = pwdata[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_id_min     <= START_ID_MIN_RST;
      cfg_q.checked_id_min   <= CHECKED_ID_MIN_RST;
      cfg_q.max_length_value <= MAX_LENGTH_VALUE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // config register reads
  always_comb begin
    case (paddr[3:2])
      REG_START_ID_MIN:     prdata = {27'd0, cfg_q.start_id_min};
      REG_CHECKED_ID_MIN:   prdata = {27'd0, cfg_q.checked_id_min};
      REG_MAX_LENGTH_VALUE: prdata = {24'd0, cfg_q.max_length_value};
      default:              prdata = 32'd0;
    endcase
  end

  bfs_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rx_i        (rx_i),
    .done_i      (done),
    .wr_o        (wr),
    .push_o      (push),
    .push_bank_o (push_bank)
  );

  bfs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_bank_i (push_bank),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .bank_o      (q_bank)
  );

  bfs_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .q_valid_i (q_valid),
    .q_bank_i  (q_bank),
    .pop_o     (pop),
    .done_o    (done),
    .frame_o   (frame_o)
  );

endmodule

`default_nettype wire
